[rtl/ansi_sgr_color_filter_top_defines.svh]
// assertion macros for the sgr color filter checker
`ifndef ANSI_SGR_COLOR_FILTER_TOP_DEFINES_SVH
`define ANSI_SGR_COLOR_FILTER_TOP_DEFINES_SVH

// condition now implies expression in the same cycle
`define SGR_ASSERT_SAME(lbl, clk, rst_n, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// condition now implies expression in the next cycle
`define SGR_ASSERT_NEXT(lbl, clk, rst_n, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[rtl/sgr_cf_pkg.sv]
// package: types, codes and helpers of the sgr color filter
`timescale 1ns / 1ps

package sgr_cf_pkg;

    localparam logic [7:0] BYTE_ESC      = 8'd27;
    localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
    localparam logic [7:0] BYTE_SEMI     = 8'h3B;
    localparam logic [7:0] BYTE_M        = 8'h6D;
    localparam logic [7:0] BYTE_PLUS     = 8'h2B;
    localparam logic [7:0] BYTE_MINUS    = 8'h2D;
    localparam logic [7:0] BYTE_SPACE    = 8'd32;
    localparam logic [7:0] BYTE_TAB      = 8'd9;
    localparam logic [7:0] BYTE_CR       = 8'd13;
    localparam logic [7:0] BYTE_ZERO     = 8'h30;
    localparam logic [7:0] BYTE_NINE     = 8'h39;

    localparam logic [7:0] FG_LOW  = 8'd30;
    localparam logic [7:0] FG_HIGH = 8'd37;
    localparam logic [7:0] BG_LOW  = 8'd40;
    localparam logic [7:0] BG_HIGH = 8'd47;
    localparam logic [7:0] VALUE_MAX = 8'd255;

    localparam logic [2:0] DEFAULT_FG_RESET = 3'd7;
    localparam logic [2:0] DEFAULT_BG_RESET = 3'd0;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_FG = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_BG = 1'b1;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_ATTR = 1'b1;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_SEQ   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        PHASE_LEAD   = 2'd0,
        PHASE_SIGNED = 2'd1,
        PHASE_DIGITS = 2'd2,
        PHASE_DONE   = 2'd3
    } t_phase;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    function automatic logic [2:0] swap_rb(input logic [2:0] c);
        swap_rb = {c[0], c[1], c[2]};
    endfunction

endpackage

[rtl/ansi_sgr_color_filter_top.sv]
// top level of the ansi sgr color filter
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+-----------------------------------
//  text in  | i_text_valid / o_text_stall    | i_text_byte
//  results  | o_res_valid / i_res_stall      | o_kind, o_payload, o_last_of_item
//  config   | i_cfg_we                       | i_cfg_index, i_cfg_data
//
// one byte per cycle while the result buffer has room; a byte is held in the input
// register, and its results are written from there into the two-entry result buffer
// the input register holds a byte until the result buffer has room for all of
// its results, so a byte giving two results waits for two free entries
// synchronous active-low reset; no clearing pass
`timescale 1ns / 1ps

module ansi_sgr_color_filter_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_text_valid,
    input  logic [7:0]                          i_text_byte,
    output logic                                o_text_stall,
    output logic                                o_res_valid,
    input  logic                                i_res_stall,
    output logic                                o_kind,
    output logic [7:0]                          o_payload,
    output logic                                o_last_of_item,
    input  logic                                i_cfg_we,
    input  logic [sgr_cf_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [sgr_cf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    sgr_cf_pkg::t_push  push;
    logic [1:0]         free;

    sgr_cf_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text_valid (i_text_valid),
        .i_text_byte  (i_text_byte),
        .o_text_stall (o_text_stall),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_free       (free),
        .o_push       (push)
    );

    sgr_cf_outbuf u_outbuf (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_free         (free),
        .o_res_valid    (o_res_valid),
        .i_res_stall    (i_res_stall),
        .o_kind         (o_kind),
        .o_payload      (o_payload),
        .o_last_of_item (o_last_of_item)
    );

endmodule

[rtl/sgr_cf_core.sv]
// input register, sgr parser state and result generation
`timescale 1ns / 1ps

module sgr_cf_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_text_valid,
    input  logic [7:0]                          i_text_byte,
    output logic                                o_text_stall,
    input  logic                                i_cfg_we,
    input  logic [sgr_cf_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [sgr_cf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [1:0]                          i_free,
    output sgr_cf_pkg::t_push                   o_push
);

    logic                 r_in_valid, n_in_valid;
    logic [7:0]           r_in_byte;
    logic [2:0]           r_default_fg, r_default_bg;
    sgr_cf_pkg::t_mode    r_mode, n_mode;
    sgr_cf_pkg::t_phase   r_phase, n_phase;
    logic                 r_neg, n_neg;
    logic [7:0]           r_value, n_value;
    logic [2:0]           r_fg, n_fg;
    logic [2:0]           r_bg, n_bg;

    logic                 accept;
    logic                 process;
    logic [7:0]           b;
    logic                 is_digit, is_space, is_sign;
    logic [11:0]          mul_sum;
    logic [7:0]           sat_value;
    logic [7:0]           fg_off, bg_off;
    logic [2:0]           fin_fg, fin_bg;
    sgr_cf_pkg::t_push    push;

    assign b = r_in_byte;
    assign is_digit = (b >= sgr_cf_pkg::BYTE_ZERO) && (b <= sgr_cf_pkg::BYTE_NINE);
    assign is_space = (b == sgr_cf_pkg::BYTE_SPACE)
                   || ((b >= sgr_cf_pkg::BYTE_TAB) && (b <= sgr_cf_pkg::BYTE_CR));
    assign is_sign  = (b == sgr_cf_pkg::BYTE_PLUS) || (b == sgr_cf_pkg::BYTE_MINUS);

    // value * 10 + digit, saturating
    assign mul_sum   = {1'b0, r_value, 3'b000} + {3'b000, r_value, 1'b0} + {8'd0, b[3:0]};
    assign sat_value = (mul_sum > {4'd0, sgr_cf_pkg::VALUE_MAX}) ? sgr_cf_pkg::VALUE_MAX
                                                                 : mul_sum[7:0];

    assign fg_off = r_value - sgr_cf_pkg::FG_LOW;
    assign bg_off = r_value - sgr_cf_pkg::BG_LOW;
    assign fin_fg = (!r_neg && r_value >= sgr_cf_pkg::FG_LOW && r_value <= sgr_cf_pkg::FG_HIGH)
                  ? sgr_cf_pkg::swap_rb(fg_off[2:0]) : r_fg;
    assign fin_bg = (!r_neg && r_value >= sgr_cf_pkg::BG_LOW && r_value <= sgr_cf_pkg::BG_HIGH)
                  ? sgr_cf_pkg::swap_rb(bg_off[2:0]) : r_bg;

    // next state
    always_comb begin
        n_mode  = r_mode;
        n_phase = r_phase;
        n_neg   = r_neg;
        n_value = r_value;
        n_fg    = r_fg;
        n_bg    = r_bg;
        unique case (r_mode)
            sgr_cf_pkg::MODE_SEQ: begin
                if (b == sgr_cf_pkg::BYTE_M || b == sgr_cf_pkg::BYTE_SEMI) begin
                    n_fg    = fin_fg;
                    n_bg    = fin_bg;
                    n_phase = sgr_cf_pkg::PHASE_LEAD;
                    n_neg   = 1'b0;
                    n_value = 8'd0;
                    if (b == sgr_cf_pkg::BYTE_M) begin
                        n_mode = sgr_cf_pkg::MODE_PLAIN;
                    end
                end else if (is_digit && r_phase != sgr_cf_pkg::PHASE_DONE) begin
                    n_value = sat_value;
                    n_phase = sgr_cf_pkg::PHASE_DIGITS;
                end else if (r_phase == sgr_cf_pkg::PHASE_LEAD && is_space) begin
                    n_phase = r_phase;
                end else if (r_phase == sgr_cf_pkg::PHASE_LEAD && is_sign) begin
                    n_neg   = (b == sgr_cf_pkg::BYTE_MINUS);
                    n_phase = sgr_cf_pkg::PHASE_SIGNED;
                end else begin
                    n_phase = sgr_cf_pkg::PHASE_DONE;
                end
            end
            sgr_cf_pkg::MODE_ESC: begin
                if (b == sgr_cf_pkg::BYTE_LBRACKET) begin
                    n_mode  = sgr_cf_pkg::MODE_SEQ;
                    n_fg    = r_default_fg;
                    n_bg    = r_default_bg;
                    n_phase = sgr_cf_pkg::PHASE_LEAD;
                    n_neg   = 1'b0;
                    n_value = 8'd0;
                end else if (b != sgr_cf_pkg::BYTE_ESC) begin
                    n_mode = sgr_cf_pkg::MODE_PLAIN;
                end
            end
            default: begin
                n_mode = (b == sgr_cf_pkg::BYTE_ESC) ? sgr_cf_pkg::MODE_ESC
                                                     : sgr_cf_pkg::MODE_PLAIN;
            end
        endcase
    end

    // results
    always_comb begin
        push.count = 2'd0;
        push.res0  = '{kind: sgr_cf_pkg::KIND_CHAR, payload: b, last: 1'b1};
        push.res1  = '{kind: sgr_cf_pkg::KIND_CHAR, payload: b, last: 1'b1};
        unique case (r_mode)
            sgr_cf_pkg::MODE_SEQ: begin
                if (b == sgr_cf_pkg::BYTE_M) begin
                    push.count = 2'd1;
                    push.res0  = '{kind: sgr_cf_pkg::KIND_ATTR,
                                   payload: {1'b0, fin_bg, 1'b0, fin_fg}, last: 1'b1};
                end
            end
            sgr_cf_pkg::MODE_ESC: begin
                if (b == sgr_cf_pkg::BYTE_ESC) begin
                    push.count = 2'd1;
                    push.res0  = '{kind: sgr_cf_pkg::KIND_CHAR,
                                   payload: sgr_cf_pkg::BYTE_ESC, last: 1'b1};
                end else if (b != sgr_cf_pkg::BYTE_LBRACKET) begin
                    push.count = 2'd2;
                    push.res0  = '{kind: sgr_cf_pkg::KIND_CHAR,
                                   payload: sgr_cf_pkg::BYTE_ESC, last: 1'b0};
                end
            end
            default: begin
                if (b != sgr_cf_pkg::BYTE_ESC) begin
                    push.count = 2'd1;
                end
            end
        endcase
    end

    assign process      = r_in_valid && (push.count <= i_free);
    assign o_text_stall = r_in_valid && !process;
    assign accept       = i_text_valid && !o_text_stall;
    assign n_in_valid   = accept || (r_in_valid && !process);

    always_comb begin
        o_push       = push;
        o_push.count = process ? push.count : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_default_fg <= sgr_cf_pkg::DEFAULT_FG_RESET;
            r_default_bg <= sgr_cf_pkg::DEFAULT_BG_RESET;
            r_mode       <= sgr_cf_pkg::MODE_PLAIN;
            r_phase      <= sgr_cf_pkg::PHASE_LEAD;
            r_neg        <= 1'b0;
            r_value      <= 8'd0;
            r_fg         <= sgr_cf_pkg::DEFAULT_FG_RESET;
            r_bg         <= sgr_cf_pkg::DEFAULT_BG_RESET;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_we && i_cfg_index == sgr_cf_pkg::CFG_DEFAULT_FG) begin
                r_default_fg <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == sgr_cf_pkg::CFG_DEFAULT_BG) begin
                r_default_bg <= i_cfg_data;
            end
            if (process) begin
                r_mode  <= n_mode;
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_value <= n_value;
                r_fg    <= n_fg;
                r_bg    <= n_bg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_text_byte;
        end
    end

endmodule

[rtl/sgr_cf_outbuf.sv]
// two-entry result buffer taking up to two results per cycle
`timescale 1ns / 1ps

module sgr_cf_outbuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sgr_cf_pkg::t_push  i_push,
    output logic [1:0]         o_free,
    output logic               o_res_valid,
    input  logic               i_res_stall,
    output logic               o_kind,
    output logic [7:0]         o_payload,
    output logic               o_last_of_item
);

    logic [1:0]           r_count, n_count;
    sgr_cf_pkg::t_result  r_slot0, n_slot0;
    sgr_cf_pkg::t_result  r_slot1, n_slot1;
    logic                 pop;
    logic [1:0]           cnt_after_pop;

    assign pop           = o_res_valid && !i_res_stall;
    assign o_free        = 2'd2 - r_count + {1'b0, pop};
    assign cnt_after_pop = r_count - {1'b0, pop};

    always_comb begin
        n_slot0 = pop ? r_slot1 : r_slot0;
        n_slot1 = r_slot1;
        if (i_push.count != 2'd0) begin
            if (cnt_after_pop == 2'd0) begin
                n_slot0 = i_push.res0;
            end else begin
                n_slot1 = i_push.res0;
            end
        end
        if (i_push.count == 2'd2) begin
            n_slot1 = i_push.res1;
        end
        n_count = cnt_after_pop + i_push.count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign o_res_valid    = (r_count != 2'd0);
    assign o_kind         = r_slot0.kind;
    assign o_payload      = r_slot0.payload;
    assign o_last_of_item = r_slot0.last;

endmodule

[rtl/sgr_cf_checker.sv]
// port-level checker for the sgr color filter and its bind
`timescale 1ns / 1ps
`include "ansi_sgr_color_filter_top_defines.svh"

module sgr_cf_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_res_valid,
    input  logic        i_res_stall,
    input  logic        o_kind,
    input  logic [7:0]  o_payload,
    input  logic        o_last_of_item
);

    // a stalled transaction keeps its payload
    `SGR_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n,
        o_res_valid && i_res_stall,
        o_res_valid && $stable(o_kind) && $stable(o_payload) && $stable(o_last_of_item),
        "stalled result changed")

    // an attribute always closes its byte
    `SGR_ASSERT_SAME(a_attr_last, i_clk, i_rst_n,
        o_res_valid && o_kind == sgr_cf_pkg::KIND_ATTR,
        o_last_of_item,
        "attribute not last")

    // only a held escape is ever followed by another result of the same byte
    `SGR_ASSERT_SAME(a_first_is_esc, i_clk, i_rst_n,
        o_res_valid && !o_last_of_item,
        o_kind == sgr_cf_pkg::KIND_CHAR && o_payload == sgr_cf_pkg::BYTE_ESC,
        "non-last result is not escape")

    // the second result of a byte is ready right behind the first
    `SGR_ASSERT_NEXT(a_pair_follows, i_clk, i_rst_n,
        o_res_valid && !o_last_of_item && !i_res_stall,
        o_res_valid && o_kind == sgr_cf_pkg::KIND_CHAR && o_last_of_item,
        "second result missing")

endmodule

bind ansi_sgr_color_filter_top sgr_cf_checker u_sgr_cf_checker (.*);
